>>> design/rtc_pkg.sv
`timescale 1ns / 1ps

package rtc_pkg;

  localparam logic [13:0] YEAR_RESET = 14'd1970;
  localparam logic [13:0] YEAR_MIN   = 14'd1970;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [4:0]  SEP_CODE   = 5'd16;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_INC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_SET  = 2'd3
  } op_e;

  localparam logic [2:0] SEL_SEC  = 3'd1;
  localparam logic [2:0] SEL_MIN  = 3'd2;
  localparam logic [2:0] SEL_HOUR = 3'd3;
  localparam logic [2:0] SEL_DAY  = 3'd4;
  localparam logic [2:0] SEL_MON  = 3'd5;
  localparam logic [2:0] SEL_YEAR = 3'd6;

  typedef enum logic [1:0] {
    K_NOP,
    K_UP,
    K_DOWN,
    K_SET
  } kind_e;

  typedef enum logic [2:0] {
    F_SEC,
    F_MIN,
    F_HOUR,
    F_DAY,
    F_MON,
    F_YEAR
  } field_e;

  typedef struct packed {
    kind_e       kind;
    field_e      field;
    logic        mode;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cmd_t;

  // Snapshot for the display: hour/minute/second or year/month/day.
  typedef struct packed {
    logic        mode;
    logic [13:0] a;
    logic [5:0]  b;
    logic [5:0]  c;
  } res_t;

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd2:                      d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Reciprocal multiplies, exact for every 14-bit value.
  function automatic logic [10:0] div10_y(input logic [13:0] v);
    logic [33:0] p;
    p = 34'(v) * 34'd52429;
    return p[29:19];
  endfunction

  function automatic logic [7:0] div100_y(input logic [13:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd5243;
    return p[26:19];
  endfunction

  function automatic logic [4:0] div1000_y(input logic [13:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'd8389;
    return p[27:23];
  endfunction

  // Exact for values below 64.
  function automatic logic [2:0] div10_s(input logic [5:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'd205;
    return p[13:11];
  endfunction

endpackage

>>> design/rtc_front.sv
`timescale 1ns / 1ps

module rtc_front import rtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  field_select_i,
  input  logic        display_mode_i,
  input  logic [13:0] set_year_i,
  input  logic [3:0]  set_month_i,
  input  logic [4:0]  set_day_i,
  input  logic [4:0]  set_hour_i,
  input  logic [5:0]  set_minute_i,
  input  logic [5:0]  set_second_i,
  output logic        q_valid_o,
  output cmd_t        q_cmd_o,
  input  logic        q_pop_i
);

  cmd_t             cmd;
  cmd_t             slot_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q;
  logic             push;

  always_comb begin
    cmd.kind   = K_NOP;
    cmd.field  = F_SEC;
    cmd.mode   = display_mode_i;
    cmd.year   = set_year_i;
    cmd.month  = set_month_i;
    cmd.day    = set_day_i;
    cmd.hour   = set_hour_i;
    cmd.minute = set_minute_i;
    cmd.second = set_second_i;
    unique case (op_e'(opcode_i))
      OP_TICK: begin
        cmd.kind = K_UP;
      end
      OP_INC, OP_DEC: begin
        cmd.kind = (op_e'(opcode_i) == OP_INC) ? K_UP : K_DOWN;
        unique case (field_select_i)
          // Both directions clear the second.
          SEL_SEC:  begin cmd.kind = K_DOWN; cmd.field = F_SEC; end
          SEL_MIN:  cmd.field = F_MIN;
          SEL_HOUR: cmd.field = F_HOUR;
          SEL_DAY:  cmd.field = F_DAY;
          SEL_MON:  cmd.field = F_MON;
          SEL_YEAR: cmd.field = F_YEAR;
          default:  cmd.kind = K_NOP;
        endcase
      end
      OP_SET: begin
        cmd.kind = K_SET;
      end
      default: cmd.kind = K_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == QCW'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_cmd_o    = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/rtc_exec.sv
`timescale 1ns / 1ps

module rtc_exec import rtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic out_stall_i
);

  logic [13:0] year_q, year_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic        res_valid_q;
  res_t        res_q;

  logic [7:0]  q100;
  logic [13:0] r100;
  logic        leap;
  logic [4:0]  dim;
  logic        is_up;
  logic        up_sec, up_min, up_hour, up_day, up_mon, up_year;

  assign q100 = div100_y(year_q);
  assign r100 = year_q - 14'(q100) * 14'd100;
  assign leap = ((year_q[1:0] == 2'b00) && (r100 != '0)) ||
                ((r100 == '0) && (q100[1:0] == 2'b00));
  assign dim  = month_days(mon_q) + 5'((mon_q == 4'd2) && leap);

  // Carry chain: each level steps when selected or when the level below wraps.
  assign is_up   = (q_cmd_i.kind == K_UP);
  assign up_sec  = is_up && (q_cmd_i.field == F_SEC);
  assign up_min  = (is_up && (q_cmd_i.field == F_MIN)) || (up_sec && (sec_q >= 6'd59));
  assign up_hour = (is_up && (q_cmd_i.field == F_HOUR)) || (up_min && (min_q >= 6'd59));
  assign up_day  = (is_up && (q_cmd_i.field == F_DAY)) || (up_hour && (hour_q >= 5'd23));
  assign up_mon  = (is_up && (q_cmd_i.field == F_MON)) || (up_day && (day_q >= dim));
  assign up_year = (is_up && (q_cmd_i.field == F_YEAR)) || (up_mon && (mon_q >= 4'd12));

  always_comb begin
    year_d = year_q;
    mon_d  = mon_q;
    day_d  = day_q;
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    unique case (q_cmd_i.kind)
      K_UP: begin
        if (up_sec)  sec_d  = (sec_q >= 6'd59) ? '0 : sec_q + 1'b1;
        if (up_min)  min_d  = (min_q >= 6'd59) ? '0 : min_q + 1'b1;
        if (up_hour) hour_d = (hour_q >= 5'd23) ? '0 : hour_q + 1'b1;
        if (up_day)  day_d  = (day_q >= dim) ? 5'd1 : day_q + 1'b1;
        if (up_mon)  mon_d  = (mon_q >= 4'd12) ? 4'd1 : mon_q + 1'b1;
        if (up_year && (year_q < YEAR_MAX)) year_d = year_q + 1'b1;
      end
      K_DOWN: begin
        unique case (q_cmd_i.field)
          F_SEC:  sec_d  = '0;
          F_MIN:  min_d  = (min_q == '0) ? 6'd59 : min_q - 1'b1;
          F_HOUR: hour_d = (hour_q == '0) ? 5'd23 : hour_q - 1'b1;
          F_DAY:  day_d  = (day_q <= 5'd1) ? dim : day_q - 1'b1;
          F_MON:  mon_d  = (mon_q <= 4'd1) ? 4'd12 : mon_q - 1'b1;
          F_YEAR: year_d = (year_q <= YEAR_MIN) ? YEAR_MIN : year_q - 1'b1;
          default: ;
        endcase
      end
      K_SET: begin
        year_d = q_cmd_i.year;
        mon_d  = q_cmd_i.month;
        day_d  = q_cmd_i.day;
        hour_d = q_cmd_i.hour;
        min_d  = q_cmd_i.minute;
        sec_d  = q_cmd_i.second;
      end
      default: ;
    endcase
  end

  assign q_pop_o     = q_valid_i && (!res_valid_q || !out_stall_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q.mode <= q_cmd_i.mode;
      if (q_cmd_i.mode) begin
        res_q.a <= year_d;
        res_q.b <= 6'(mon_d);
        res_q.c <= 6'(day_d);
      end else begin
        res_q.a <= 14'(hour_d);
        res_q.b <= min_d;
        res_q.c <= sec_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q      <= YEAR_RESET;
      mon_q       <= 4'd1;
      day_q       <= 5'd1;
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        year_q <= year_d;
        mon_q  <= mon_d;
        day_q  <= day_d;
        hour_q <= hour_d;
        min_q  <= min_d;
        sec_q  <= sec_d;
      end
      if (q_pop_o) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> design/rtc_digits.sv
`timescale 1ns / 1ps

module rtc_digits import rtc_pkg::*; (
  input  res_t            res_i,
  output logic [7:0][4:0] digits_o
);

  logic [10:0] q10;
  logic [7:0]  q100;
  logic [4:0]  q1000;
  logic [2:0]  at, bt, ct;
  logic [3:0]  au, bu, cu;
  logic [3:0]  y0, y1, y2, y3;

  assign q10   = div10_y(res_i.a);
  assign q100  = div100_y(res_i.a);
  assign q1000 = div1000_y(res_i.a);

  assign y3 = 4'(res_i.a - 14'(q10) * 14'd10);
  assign y2 = 4'(q10 - 11'(q100) * 11'd10);
  assign y1 = 4'(q100 - 8'(q1000) * 8'd10);
  // Raw loaded years reach 16383, so the thousands count can pass nine.
  assign y0 = 4'((q1000 >= 5'd10) ? q1000 - 5'd10 : q1000);

  assign at = div10_s(res_i.a[5:0]);
  assign bt = div10_s(res_i.b);
  assign ct = div10_s(res_i.c);
  assign au = 4'(res_i.a[5:0] - 6'(at) * 6'd10);
  assign bu = 4'(res_i.b - 6'(bt) * 6'd10);
  assign cu = 4'(res_i.c - 6'(ct) * 6'd10);

  always_comb begin
    if (res_i.mode) begin
      digits_o[0] = 5'(y0);
      digits_o[1] = 5'(y1);
      digits_o[2] = 5'(y2);
      digits_o[3] = 5'(y3);
      digits_o[4] = 5'(bt);
      digits_o[5] = 5'(bu);
      digits_o[6] = 5'(ct);
      digits_o[7] = 5'(cu);
    end else begin
      digits_o[0] = 5'(at);
      digits_o[1] = 5'(au);
      digits_o[2] = SEP_CODE;
      digits_o[3] = 5'(bt);
      digits_o[4] = 5'(bu);
      digits_o[5] = SEP_CODE;
      digits_o[6] = 5'(ct);
      digits_o[7] = 5'(cu);
    end
  end

endmodule

>>> design/calendar_clock_with_adjust_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// in        in_valid_i / in_stall_o  opcode_i, field_select_i, display_mode_i, set_*_i
// out       out_valid_o / out_stall_i digit0_o .. digit7_o
//
// One request per cycle sustained while the output does not stall. A request is
// written into the queue when accepted; when popped, it updates the calendar into the
// result register. A pop waits while a valid result is held by a stalled output.
// A two-entry command queue decouples the input side from the update logic.
// Reset loads 1970-01-01 00:00:00 and empties the queue and the result register.
// A stalled output holds its digits; the input stalls once the queue is full.

module calendar_clock_with_adjust_core import rtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  field_select_i,
  input  logic        display_mode_i,
  input  logic [13:0] set_year_i,
  input  logic [3:0]  set_month_i,
  input  logic [4:0]  set_day_i,
  input  logic [4:0]  set_hour_i,
  input  logic [5:0]  set_minute_i,
  input  logic [5:0]  set_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  digit0_o,
  output logic [4:0]  digit1_o,
  output logic [4:0]  digit2_o,
  output logic [4:0]  digit3_o,
  output logic [4:0]  digit4_o,
  output logic [4:0]  digit5_o,
  output logic [4:0]  digit6_o,
  output logic [4:0]  digit7_o
);

  logic            q_valid;
  logic            q_pop;
  cmd_t            q_cmd;
  res_t            res;
  logic [7:0][4:0] digits;

  rtc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .field_select_i (field_select_i),
    .display_mode_i (display_mode_i),
    .set_year_i     (set_year_i),
    .set_month_i    (set_month_i),
    .set_day_i      (set_day_i),
    .set_hour_i     (set_hour_i),
    .set_minute_i   (set_minute_i),
    .set_second_i   (set_second_i),
    .q_valid_o      (q_valid),
    .q_cmd_o        (q_cmd),
    .q_pop_i        (q_pop)
  );

  rtc_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .out_stall_i (out_stall_i)
  );

  rtc_digits u_digits (
    .res_i    (res),
    .digits_o (digits)
  );

  assign digit0_o = digits[0];
  assign digit1_o = digits[1];
  assign digit2_o = digits[2];
  assign digit3_o = digits[3];
  assign digit4_o = digits[4];
  assign digit5_o = digits[5];
  assign digit6_o = digits[6];
  assign digit7_o = digits[7];

endmodule
